// ----- rtl/shl_pkg.sv -----
// Package with constants and types for the spherical harmonics lighting store.
package shl_pkg;
  localparam logic [2:0] OP_CLEAR = 3'd0;
  localparam logic [2:0] OP_ADD = 3'd1;
  localparam logic [2:0] OP_IRR = 3'd2;
  localparam logic [2:0] OP_RAD = 3'd3;
  localparam logic [2:0] OP_SCALE = 3'd4;

  localparam int NUM_COEF = 27;

  localparam logic signed [31:0] K0 = 32'sd302896976;
  localparam logic signed [31:0] K1 = 32'sd524632952;
  localparam logic signed [31:0] K6A = 32'sd1015947344;
  localparam logic signed [31:0] K6B = 32'sd338649115;
  localparam logic signed [31:0] K2 = 32'sd1173114945;
  localparam logic signed [31:0] K8 = 32'sd586557472;

  // Rounded basis constants and band weights, Q2.30.
  localparam logic [63:0] L0 = 64'd302897200;
  localparam logic [63:0] L1 = 64'd524633476;
  localparam logic [63:0] L2 = 64'd1173114482;
  localparam logic [63:0] L6 = 64'd338649581;
  localparam logic [63:0] L8 = 64'd586557241;
  localparam logic [63:0] BW_PI = 64'd3373259426;
  localparam logic [63:0] BW_A1 = 64'd2248839618;
  localparam logic [63:0] BW_A2 = 64'd843314857;

  // Lookup constants: basis constant times band weight, Q2.30.
  localparam logic signed [32:0] IRR_K0 = 33'((L0 * BW_PI + (64'd1 << 29)) >> 30);
  localparam logic signed [32:0] IRR_K1 = 33'((L1 * BW_A1 + (64'd1 << 29)) >> 30);
  localparam logic signed [32:0] IRR_K2 = 33'((L2 * BW_A2 + (64'd1 << 29)) >> 30);
  localparam logic signed [32:0] IRR_K6 = 33'((L6 * BW_A2 + (64'd1 << 29)) >> 30);
  localparam logic signed [32:0] IRR_K8 = 33'((L8 * BW_A2 + (64'd1 << 29)) >> 30);
  localparam logic signed [32:0] RAD_K0 = 33'((L0 * BW_PI + (64'd1 << 29)) >> 30);
  localparam logic signed [32:0] RAD_K1 = 33'((L1 * BW_PI + (64'd1 << 29)) >> 30);
  localparam logic signed [32:0] RAD_K2 = 33'((L2 * BW_PI + (64'd1 << 29)) >> 30);
  localparam logic signed [32:0] RAD_K6 = 33'((L6 * BW_PI + (64'd1 << 29)) >> 30);
  localparam logic signed [32:0] RAD_K8 = 33'((L8 * BW_PI + (64'd1 << 29)) >> 30);

  typedef struct packed {
    logic [2:0] operation;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic signed [15:0] color_r;
    logic signed [15:0] color_g;
    logic signed [15:0] color_b;
    logic [15:0] scale_factor;
  } req_t;
endpackage

// ----- rtl/shl_ram.sv -----
// Generic RAM with one write port, one read port and registered read data.
module shl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 27
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/shl_basis.sv -----
// Basis weight computation for add and lookup requests, one term per cycle.
module shl_basis
  import shl_pkg::*;
(
  input  logic               clk,
  input  logic               start,
  input  logic [2:0]         op,
  input  logic signed [15:0] dx,
  input  logic signed [15:0] dy,
  input  logic signed [15:0] dz,
  input  logic [3:0]         term,
  output logic signed [47:0] weight
);
  logic signed [16:0] nx, ny, nz;
  logic signed [34:0] pxy, pyz, pxz, pzz, pdiff;
  logic signed [34:0] p_sel;
  logic signed [32:0] k_sel;
  logic signed [67:0] prod;
  logic [5:0] sh;
  logic signed [47:0] rounded;
  logic signed [47:0] w_next;
  logic is_add, is_irr;

  always_ff @(posedge clk) begin
    if (start) begin
      is_add <= (op == OP_ADD);
      is_irr <= (op == OP_IRR);
      nx <= (op == OP_ADD) ? -17'(dx) : 17'(dx);
      ny <= (op == OP_ADD) ? -17'(dy) : 17'(dy);
      nz <= 17'(dz);
    end
  end

  always_ff @(posedge clk) begin
    pxy <= 35'(nx * ny);
    pyz <= 35'(ny * nz);
    pxz <= 35'(nx * nz);
    pzz <= 35'(nz * nz);
    pdiff <= 35'(nx * nx) - 35'(ny * ny);
  end

  always_comb begin
    k_sel = '0;
    p_sel = '0;
    sh = 6'd0;
    unique case (term)
      4'd0: begin
        k_sel = is_add ? 33'(K0) : (is_irr ? IRR_K0 : RAD_K0);
        p_sel = 35'sd1; sh = is_add ? 6'd0 : 6'd14;
      end
      4'd1: begin
        k_sel = is_add ? -33'(K1) : (is_irr ? IRR_K1 : RAD_K1);
        p_sel = 35'(ny); sh = is_add ? 6'd14 : 6'd28;
      end
      4'd2: begin
        k_sel = is_add ? 33'(K1) : (is_irr ? IRR_K1 : RAD_K1);
        p_sel = 35'(nz); sh = is_add ? 6'd14 : 6'd28;
      end
      4'd3: begin
        k_sel = is_add ? -33'(K1) : (is_irr ? IRR_K1 : RAD_K1);
        p_sel = 35'(nx); sh = is_add ? 6'd14 : 6'd28;
      end
      4'd4: begin
        k_sel = is_add ? 33'(K8) : (is_irr ? IRR_K2 : RAD_K2);
        p_sel = is_add ? (pxy <<< 1) : pxy; sh = is_add ? 6'd28 : 6'd42;
      end
      4'd5: begin
        k_sel = is_add ? -33'(K2) : (is_irr ? IRR_K2 : RAD_K2);
        p_sel = pyz; sh = is_add ? 6'd28 : 6'd42;
      end
      4'd6: begin
        k_sel = is_add ? 33'(K6A) : (is_irr ? IRR_K6 : RAD_K6);
        p_sel = is_add ? pzz : (pzz + (pzz <<< 1) - (35'sd1 <<< 28));
        sh = is_add ? 6'd28 : 6'd42;
      end
      4'd7: begin
        k_sel = is_add ? -33'(K2) : (is_irr ? IRR_K2 : RAD_K2);
        p_sel = pxz; sh = is_add ? 6'd28 : 6'd42;
      end
      4'd8: begin
        k_sel = is_add ? 33'(K8) : (is_irr ? IRR_K8 : RAD_K8);
        p_sel = pdiff; sh = is_add ? 6'd28 : 6'd42;
      end
      default: begin
        k_sel = '0; p_sel = '0; sh = 6'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= 68'(k_sel) * 68'(p_sel);
  end

  logic [5:0] sh_q;
  logic sub6;
  always_ff @(posedge clk) begin
    sh_q <= sh;
    sub6 <= is_add && (term == 4'd6);
  end

  always_comb begin
    if (sh_q == 6'd0) begin
      rounded = 48'(prod);
    end else begin
      rounded = 48'((prod + (68'sd1 <<< (sh_q - 6'd1))) >>> sh_q);
    end
    w_next = sub6 ? rounded - 48'(K6B) : rounded;
  end

  always_ff @(posedge clk) begin
    weight <= w_next;
  end
endmodule

// ----- rtl/shl_datapath.sv -----
// Sequencer and multiply-accumulate unit over the coefficient memory.
module shl_datapath
  import shl_pkg::*;
#(
  parameter int COEF_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  req_t        req,
  output logic        busy,
  output logic        res_valid,
  output logic [95:0] res_data
);
  localparam int AW = 5;
  localparam int CW = COEF_WIDTH;
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_BASIS = 3'd1;
  localparam logic [2:0] S_RUN = 3'd2;
  localparam logic [2:0] S_DONE = 3'd3;
  localparam logic [2:0] S_CLR = 3'd4;

  logic [2:0] state;
  req_t r;
  logic [3:0] bterm;
  logic [3:0] bcnt;
  logic signed [47:0] weight;
  logic signed [47:0] w_tab [9];
  logic [AW-1:0] idx;
  logic [3:0] ci;
  logic [1:0] ch;
  logic rd_v, wr_v;
  logic [AW-1:0] rd_idx;
  logic [3:0] rd_ci;
  logic [1:0] rd_ch;
  logic we;
  logic [AW-1:0] waddr;
  logic [CW-1:0] wdata, rdata;
  logic signed [CW-1:0] cval;
  logic signed [15:0] col;
  logic signed [95:0] prod;
  logic signed [95:0] rsum;
  logic signed [CW-1:0] sat_val;
  logic signed [63:0] acc [3];
  logic signed [31:0] osat [3];
  logic signed [CW-1:0] cmax, cmin;
  logic signed [CW-1:0] lo, hi;
  logic signed [CW+17:0] hprod;
  logic signed [95:0] lprod;
  logic signed [63:0] term_sum;

  assign cmax = {1'b0, {(CW-1){1'b1}}};
  assign cmin = {1'b1, {(CW-1){1'b0}}};

  shl_basis u_basis (
    .clk(clk), .start(start), .op(req.operation), .dx(req.dir_x),
    .dy(req.dir_y), .dz(req.dir_z), .term(bterm), .weight(weight)
  );

  shl_ram #(.WIDTH(CW), .DEPTH(NUM_COEF)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(idx), .rdata(rdata)
  );

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      idx <= '0;
      ci <= '0;
      ch <= '0;
      rd_v <= 1'b0;
      bcnt <= '0;
      bterm <= '0;
      res_valid <= 1'b0;
    end else begin
      res_valid <= 1'b0;
      rd_v <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            r <= req;
            idx <= '0;
            ci <= '0;
            ch <= '0;
            bterm <= '0;
            bcnt <= '0;
            acc[0] <= '0;
            acc[1] <= '0;
            acc[2] <= '0;
            priority if (req.operation == OP_CLEAR) state <= S_CLR;
            else if (req.operation == OP_SCALE) state <= S_RUN;
            else if (req.operation == OP_ADD || req.operation == OP_IRR ||
                     req.operation == OP_RAD) state <= S_BASIS;
            else state <= S_IDLE;
          end
        end
        S_BASIS: begin
          // Each weight passes the product register and the weight register after its term index.
          if (bterm != 4'd15) bterm <= bterm + 4'd1;
          if (bterm >= 4'd2) begin
            w_tab[bterm - 4'd2] <= weight;
            if (bterm == 4'd10) state <= S_RUN;
          end
        end
        S_RUN: begin
          if (idx != 5'(NUM_COEF)) begin
            rd_v <= 1'b1;
            rd_idx <= idx;
            rd_ci <= ci;
            rd_ch <= ch;
            idx <= idx + 5'd1;
            if (ch == 2'd2) begin
              ch <= '0;
              ci <= ci + 4'd1;
            end else begin
              ch <= ch + 2'd1;
            end
          end else if (!rd_v && !wr_v) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (r.operation == OP_IRR || r.operation == OP_RAD) res_valid <= 1'b1;
          state <= S_IDLE;
        end
        S_CLR: begin
          if (idx == 5'(NUM_COEF - 1)) begin
            state <= S_IDLE;
            idx <= '0;
          end else begin
            idx <= idx + 5'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (wr_v && (r.operation == OP_IRR || r.operation == OP_RAD)) begin
        acc[rd_ch] <= acc[rd_ch] + term_sum;
      end
    end
  end

  // Read data is valid in the cycle after the read; the write happens in that same cycle.
  assign wr_v = rd_v;

  logic [AW-1:0] w_idx;
  logic [3:0] w_ci;
  logic [1:0] w_ch;
  assign w_idx = rd_idx;
  assign w_ci = rd_ci;
  assign w_ch = rd_ch;

  assign cval = rdata;
  always_comb begin
    unique case (w_ch)
      2'd0: col = r.color_r;
      2'd1: col = r.color_g;
      default: col = r.color_b;
    endcase
    lo = CW'({1'b0, rdata[15:0]});
    hi = cval >>> 16;
    hprod = (CW+18)'(hi) * (CW+18)'(w_tab[w_ci]);
    lprod = 96'(lo) * 96'(w_tab[w_ci]);
    term_sum = 64'(hprod) + 64'((lprod + 96'sd32768) >>> 16);
    if (r.operation == OP_SCALE) begin
      prod = 96'(cval) * 96'($signed({1'b0, r.scale_factor}));
      rsum = (prod + 96'sd128) >>> 8;
    end else begin
      prod = 96'(col) * 96'(w_tab[w_ci]);
      rsum = 96'(cval) + ((prod + 96'sd524288) >>> 20);
    end
    if (rsum > 96'(cmax)) sat_val = cmax;
    else if (rsum < 96'(cmin)) sat_val = cmin;
    else sat_val = rsum[CW-1:0];
  end

  always_comb begin
    if (state == S_CLR) begin
      we = 1'b1;
      waddr = idx;
      wdata = '0;
    end else begin
      we = wr_v && (r.operation == OP_ADD || r.operation == OP_SCALE);
      waddr = w_idx;
      wdata = sat_val;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (acc[i] > 64'sd2147483647) osat[i] = 32'sh7fffffff;
      else if (acc[i] < -64'sd2147483648) osat[i] = 32'sh80000000;
      else osat[i] = acc[i][31:0];
    end
  end

  assign res_data = {osat[2], osat[1], osat[0]};
endmodule

// ----- rtl/sh_order2_light_accumulate_eval_top.sv -----
// Top level of the order-2 spherical harmonics lighting store.
//
// Requests arrive on the s_axis channel; tdata carries operation, the three
// direction components, the three color components and the scale factor.
// Clear, add and scale update the 27 stored coefficients and give no result.
// Irradiance and radiance lookups give one RGB result on m_axis.
// One request is worked at a time. The coefficients sit in a memory with
// one write and one read port that one multiply-accumulate unit sweeps once
// per add, scale or lookup, one entry per cycle. An add computes the basis
// weights, sweeps the memory, finishes and then takes the next request. A
// lookup does the same and offers its result; the next request can follow
// when the receiver is ready. Scale sweeps without basis weights, clear
// zeroes every entry, and an unused operation code has no effect.
// After reset a clearing pass zeroes all 27 entries of the memory before the
// first request is taken. A result waits in an output register while the
// receiver stalls, and no new request is taken until it is delivered.
module sh_order2_light_accumulate_eval_top
  import shl_pkg::*;
#(
  parameter int COEF_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // operation[2:0], dir_x, dir_y, dir_z, color_r, color_g, color_b, scale_factor
  input  logic [119:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_r[31:0], out_g[63:32], out_b[95:64]
  output logic [95:0]  m_axis_tdata
);
  req_t req;
  logic busy, res_valid, start;
  logic [95:0] res_data;

  assign req.operation = s_axis_tdata[2:0];
  assign req.dir_x = s_axis_tdata[18:3];
  assign req.dir_y = s_axis_tdata[34:19];
  assign req.dir_z = s_axis_tdata[50:35];
  assign req.color_r = s_axis_tdata[66:51];
  assign req.color_g = s_axis_tdata[82:67];
  assign req.color_b = s_axis_tdata[98:83];
  assign req.scale_factor = s_axis_tdata[114:99];

  assign s_axis_tready = !busy && !m_axis_tvalid && !res_valid;
  assign start = s_axis_tvalid && s_axis_tready;

  shl_datapath #(.COEF_WIDTH(COEF_WIDTH)) u_dp (
    .clk(clk), .rst(rst), .start(start), .req(req), .busy(busy),
    .res_valid(res_valid), .res_data(res_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) m_axis_tdata <= res_data;
  end
endmodule
